// File: rtl/c2d4_pkg.sv
// Shared types, constants and register codes for the 4x4 convolution stream unit.
package c2d4_pkg;

  localparam int PIX_W      = 8;
  localparam int COEF_W     = 8;
  localparam int KSIZE      = 4;
  localparam int TAPS       = KSIZE * KSIZE;
  localparam int PROD_W     = PIX_W + COEF_W;
  localparam int PART_W     = PROD_W + 2;
  localparam int SUM_W      = 20;
  localparam int IMG_W_W    = 7;
  localparam int IMG_H_W    = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;
  localparam int LINE_W     = PIX_W * (KSIZE - 1);

  localparam int DEF_MAX_WIDTH = 64;

  localparam logic [CFG_DATA_W-1:0] RST_COEF01 = 64'h0001_0100_0100_0001;
  localparam logic [CFG_DATA_W-1:0] RST_COEF23 = 64'h0100_0001_0001_0100;
  localparam logic [IMG_W_W-1:0]    RST_IMG_W  = 7'd48;
  localparam logic [IMG_H_W-1:0]    RST_IMG_H  = 16'd48;
  localparam logic [IMG_W_W-1:0]    MIN_IMG_W  = 7'd4;
  localparam logic [IMG_H_W-1:0]    MIN_IMG_H  = 16'd4;
  localparam logic [IMG_H_W-1:0]    FIRST_ROW  = 16'd3;

  typedef enum logic [1:0] {
    REG_COEF01 = 2'd0,
    REG_COEF23 = 2'd1,
    REG_IMG_W  = 2'd2,
    REG_IMG_H  = 2'd3
  } reg_idx_t;

  typedef logic [PIX_W-1:0] win_t [TAPS];

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

endpackage

// File: rtl/c2d4_mac.sv
// Multiply-accumulate pipeline: sixteen products, four partial sums, final sum.
module c2d4_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             en,
  input  c2d4_pkg::win_t                   win,
  input  logic [c2d4_pkg::CFG_DATA_W-1:0]  coef01,
  input  logic [c2d4_pkg::CFG_DATA_W-1:0]  coef23,
  input  c2d4_pkg::ctl_t                   ctl_in,
  output c2d4_pkg::ctl_t                   ctl_out,
  output logic [c2d4_pkg::SUM_W-1:0]       sum
);

  logic [c2d4_pkg::COEF_W-1:0] coef [c2d4_pkg::TAPS];
  logic [c2d4_pkg::PROD_W-1:0] prod [c2d4_pkg::TAPS];
  logic [c2d4_pkg::PART_W-1:0] part [c2d4_pkg::KSIZE];
  c2d4_pkg::ctl_t              prod_ctl;
  c2d4_pkg::ctl_t              part_ctl;

  for (genvar k = 0; k < c2d4_pkg::TAPS; k++) begin : g_coef
    if (k < 8) begin : g_lo
      assign coef[k] = coef01[8*k +: 8];
    end else begin : g_hi
      assign coef[k] = coef23[8*(k-8) +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_ctl <= '0;
      part_ctl <= '0;
      ctl_out  <= '0;
    end else if (en) begin
      prod_ctl <= ctl_in;
      part_ctl <= prod_ctl;
      ctl_out  <= part_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < c2d4_pkg::TAPS; k++) begin
        prod[k] <= c2d4_pkg::PROD_W'(win[k]) * c2d4_pkg::PROD_W'(coef[k]);
      end
      // one partial sum per kernel row
      for (int r = 0; r < c2d4_pkg::KSIZE; r++) begin
        part[r] <= c2d4_pkg::PART_W'(prod[4*r]) + c2d4_pkg::PART_W'(prod[4*r+1])
                 + c2d4_pkg::PART_W'(prod[4*r+2]) + c2d4_pkg::PART_W'(prod[4*r+3]);
      end
      sum <= c2d4_pkg::SUM_W'(part[0]) + c2d4_pkg::SUM_W'(part[1])
           + c2d4_pkg::SUM_W'(part[2]) + c2d4_pkg::SUM_W'(part[3]);
    end
  end

endmodule

// File: rtl/conv2d_4x4_valid_stream_unit.sv
// Top level: 4x4 valid-mode correlation over a raster pixel stream.
//
//  channel   dir  handshake             word
//  -------   ---  --------------------  ---------------------------------
//  input     in   in_valid / in_ready   pixel[7:0]
//  output    out  out_valid / out_ready window_sum[19:0], frame_last
//  config    in   psel/penable/pwrite   paddr[4:3] = register, pwdata[63:0]
//
// Throughput: one pixel per cycle while out_ready does not stall the output.
// Stages from accept to out_valid: line-store read, window shift, products,
// row sums, final sum. The line store is one synchronous memory of MAX_WIDTH
// entries holding the three previous rows of a column; it is read on accept
// and written back from stage 1 while enabled. Reset (synchronous) clears
// counters, stage valids and the per-column valid bits; an unwritten column
// reads as zero. A stalled output freezes the whole pipeline, so in_ready
// follows out_ready whenever a word sits in the output register.
module conv2d_4x4_valid_stream_unit #(
  parameter int MAX_WIDTH = c2d4_pkg::DEF_MAX_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // pixel stream in
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [c2d4_pkg::PIX_W-1:0]       pixel,
  // result stream out
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [c2d4_pkg::SUM_W-1:0]       window_sum,
  output logic                             frame_last,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [c2d4_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [c2d4_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [c2d4_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  // wide enough for the width register and for MAX_WIDTH itself
  localparam int WW = (CW + 1 > c2d4_pkg::IMG_W_W) ? CW + 1 : c2d4_pkg::IMG_W_W;

  // ---------------- registers ----------------
  logic [c2d4_pkg::CFG_DATA_W-1:0] coef01;
  logic [c2d4_pkg::CFG_DATA_W-1:0] coef23;
  logic [c2d4_pkg::IMG_W_W-1:0]    img_w;
  logic [c2d4_pkg::IMG_H_W-1:0]    img_h;
  c2d4_pkg::reg_idx_t              reg_sel;
  logic                            cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = c2d4_pkg::reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef01 <= c2d4_pkg::RST_COEF01;
      coef23 <= c2d4_pkg::RST_COEF23;
      img_w  <= c2d4_pkg::RST_IMG_W;
      img_h  <= c2d4_pkg::RST_IMG_H;
    end else if (cfg_wr) begin
      case (reg_sel)
        c2d4_pkg::REG_COEF01: coef01 <= pwdata;
        c2d4_pkg::REG_COEF23: coef23 <= pwdata;
        c2d4_pkg::REG_IMG_W:  img_w  <= pwdata[c2d4_pkg::IMG_W_W-1:0];
        c2d4_pkg::REG_IMG_H:  img_h  <= pwdata[c2d4_pkg::IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      c2d4_pkg::REG_COEF01: prdata = coef01;
      c2d4_pkg::REG_COEF23: prdata = coef23;
      c2d4_pkg::REG_IMG_W:  prdata = c2d4_pkg::CFG_DATA_W'(img_w);
      c2d4_pkg::REG_IMG_H:  prdata = c2d4_pkg::CFG_DATA_W'(img_h);
      default:              prdata = '0;
    endcase
  end

  // ---------------- pipeline enable ----------------
  c2d4_pkg::ctl_t out_ctl;
  logic           en;
  logic           accept;

  assign en        = !out_ctl.valid || out_ready;
  assign in_ready  = en;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_ctl.valid;
  assign frame_last = out_ctl.last;

  // ---------------- position counters ----------------
  logic [CW-1:0]               col_cnt;
  logic [c2d4_pkg::IMG_H_W-1:0] row_cnt;
  logic [WW-1:0]               w_use;
  logic [c2d4_pkg::IMG_H_W-1:0] h_use;
  logic                        row_end;
  logic                        frame_end;
  logic                        emit;

  always_comb begin
    if (img_w < c2d4_pkg::MIN_IMG_W) begin
      w_use = WW'(c2d4_pkg::MIN_IMG_W);
    end else if (WW'(img_w) > WW'(MAX_WIDTH)) begin
      w_use = WW'(MAX_WIDTH);
    end else begin
      w_use = WW'(img_w);
    end
    h_use = (img_h < c2d4_pkg::MIN_IMG_H) ? c2d4_pkg::MIN_IMG_H : img_h;
  end

  assign row_end   = (WW'(col_cnt) + WW'(1)) >= w_use;
  assign frame_end = ({1'b0, row_cnt} + 17'd1) >= {1'b0, h_use};
  assign emit      = (row_cnt >= c2d4_pkg::FIRST_ROW) && (WW'(col_cnt) >= WW'(3));

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_cnt <= '0;
        row_cnt <= frame_end ? '0 : row_cnt + 1'b1;
      end else begin
        col_cnt <= col_cnt + 1'b1;
      end
    end
  end

  // ---------------- line store ----------------
  // entry = {row r-3, row r-2, row r-1} of one column
  logic [c2d4_pkg::LINE_W-1:0] line_mem [MAX_WIDTH];
  logic [MAX_WIDTH-1:0]        line_vld;
  logic [c2d4_pkg::LINE_W-1:0] rd_data;
  logic                        rd_vld;
  logic                        wr_en;
  logic [c2d4_pkg::LINE_W-1:0] wr_data;

  // stage 1: pixel waiting for its column from the store
  logic                        s1_valid;
  logic                        s1_emit;
  logic                        s1_last;
  logic [CW-1:0]               s1_col;
  logic [c2d4_pkg::PIX_W-1:0]  s1_pix;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[col_cnt];
      rd_vld  <= line_vld[col_cnt];
    end
    if (wr_en) begin
      line_mem[s1_col] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_vld <= '0;
    end else if (wr_en) begin
      line_vld[s1_col] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit <= emit;
      s1_last <= row_end && frame_end;
      s1_col  <= col_cnt;
      s1_pix  <= pixel;
    end
  end

  // ---------------- window ----------------
  logic [c2d4_pkg::LINE_W-1:0] line_q;
  logic [c2d4_pkg::PIX_W-1:0]  new_col [c2d4_pkg::KSIZE];
  c2d4_pkg::win_t              win;
  c2d4_pkg::ctl_t              s2_ctl;

  assign line_q     = rd_vld ? rd_data : '0;
  assign new_col[0] = line_q[23:16];
  assign new_col[1] = line_q[15:8];
  assign new_col[2] = line_q[7:0];
  assign new_col[3] = s1_pix;
  assign wr_en      = en && s1_valid;
  assign wr_data    = {line_q[15:8], line_q[7:0], s1_pix};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < c2d4_pkg::KSIZE; i++) begin
        for (int j = 0; j < c2d4_pkg::KSIZE - 1; j++) begin
          win[i*c2d4_pkg::KSIZE + j] <= win[i*c2d4_pkg::KSIZE + j + 1];
        end
        win[i*c2d4_pkg::KSIZE + c2d4_pkg::KSIZE - 1] <= new_col[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (en) begin
      s2_ctl.valid <= s1_valid && s1_emit;
      s2_ctl.last  <= s1_valid && s1_emit && s1_last;
    end
  end

  // ---------------- arithmetic ----------------
  c2d4_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .win     (win),
    .coef01  (coef01),
    .coef23  (coef23),
    .ctl_in  (s2_ctl),
    .ctl_out (out_ctl),
    .sum     (window_sum)
  );

  // ---------------- checks ----------------
  // a store read never hits the column being written back
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (accept && wr_en) |-> (col_cnt != s1_col))
    else $error("line store read and write on the same column");

  // column counter stays inside the store
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    WW'(col_cnt) < WW'(MAX_WIDTH))
    else $error("column counter beyond store depth");

  // a frame end is only flagged on a word that is produced
  a_last_emit: assert property (@(posedge clk) disable iff (rst)
    s2_ctl.last |-> s2_ctl.valid)
    else $error("frame end flag without a result word");

  // a stalled pipeline leaves the window alone (checked on its last tap)
  a_win_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(win[c2d4_pkg::TAPS-1]))
    else $error("window changed during a stall");

endmodule

// File: tb/tb_conv2d_4x4_valid_stream_unit.sv
// Self-checking testbench for the 4x4 valid-mode convolution stream unit.
module tb_conv2d_4x4_valid_stream_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW         = c2d4_pkg::DEF_MAX_WIDTH;
  localparam int CYCLE_LIMIT  = 1_000_000;
  // pipeline is five deep; words that make no result may still be in flight
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 520;

  typedef struct packed {
    logic [c2d4_pkg::SUM_W-1:0] sum;
    logic                       last;
  } sum_word_t;

  // ---------------------------------------------------------------------------
  // DUT ports, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  logic [c2d4_pkg::PIX_W-1:0]      pixel     = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic [c2d4_pkg::SUM_W-1:0]      window_sum;
  logic                            frame_last;
  logic                            psel      = 1'b0;
  logic                            penable   = 1'b0;
  logic                            pwrite    = 1'b0;
  logic [c2d4_pkg::CFG_ADDR_W-1:0] paddr     = '0;
  logic [c2d4_pkg::CFG_DATA_W-1:0] pwdata    = '0;
  logic [c2d4_pkg::CFG_DATA_W-1:0] prdata;
  logic                            pready;

  conv2d_4x4_valid_stream_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .pixel      (pixel),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .window_sum (window_sum),
    .frame_last (frame_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the registers and of the datapath state
  // ---------------------------------------------------------------------------
  logic [c2d4_pkg::CFG_DATA_W-1:0] coef01 = c2d4_pkg::RST_COEF01;
  logic [c2d4_pkg::CFG_DATA_W-1:0] coef23 = c2d4_pkg::RST_COEF23;
  logic [c2d4_pkg::IMG_W_W-1:0]    img_w  = c2d4_pkg::RST_IMG_W;
  logic [c2d4_pkg::IMG_H_W-1:0]    img_h  = c2d4_pkg::RST_IMG_H;

  // line_mem[0] = row r-1, [1] = row r-2, [2] = row r-3
  logic [c2d4_pkg::PIX_W-1:0] line_mem [c2d4_pkg::KSIZE-1][MAXW];
  // win[row][col]: row 0 oldest image row, col 0 leftmost
  logic [c2d4_pkg::PIX_W-1:0] win [c2d4_pkg::KSIZE][c2d4_pkg::KSIZE];
  int unsigned      col_cnt = 0;
  int unsigned      row_cnt = 0;

  sum_word_t expected_sums[$];
  int        errors = 0;
  int        cycles = 0;
  bit        steady = 1'b0;   // no idling on either side while set
  int unsigned ready_hold = 0;

  initial begin
    foreach (line_mem[i, j]) line_mem[i][j] = '0;
    foreach (win[i, j]) win[i][j] = '0;
  end

  function automatic int unsigned kernel_tap(input int unsigned k);
    logic [c2d4_pkg::CFG_DATA_W-1:0] row_pair;
    row_pair = (k < 8) ? coef01 : coef23;
    return 32'(row_pair[(k % 8) * c2d4_pkg::COEF_W +: c2d4_pkg::COEF_W]);
  endfunction

  // clamped sizes actually used by the datapath
  function automatic int unsigned width_used();
    int unsigned w;
    w = 32'(img_w);
    if (w < 4) w = 4;
    if (w > MAXW) w = MAXW;
    return w;
  endfunction

  function automatic int unsigned height_used();
    int unsigned h;
    h = 32'(img_h);
    if (h < 4) h = 4;
    return h;
  endfunction

  function automatic logic [c2d4_pkg::CFG_DATA_W-1:0] reg_view(
    input c2d4_pkg::reg_idx_t idx
  );
    logic [c2d4_pkg::CFG_DATA_W-1:0] v;
    v = '0;
    case (idx)
      c2d4_pkg::REG_COEF01: v = coef01;
      c2d4_pkg::REG_COEF23: v = coef23;
      c2d4_pkg::REG_IMG_W:  v[c2d4_pkg::IMG_W_W-1:0] = img_w;
      c2d4_pkg::REG_IMG_H:  v[c2d4_pkg::IMG_H_W-1:0] = img_h;
      default: ;
    endcase
    return v;
  endfunction

  // Advance the shadow state by one pixel; queue a sum when the window is full.
  task automatic convolve_pixel(input logic [c2d4_pkg::PIX_W-1:0] px);
    int unsigned                w, h, c, acc;
    logic [c2d4_pkg::PIX_W-1:0] fresh [c2d4_pkg::KSIZE];
    bit                         row_end, frame_end;
    sum_word_t                  word;
    w = width_used();
    h = height_used();
    c = col_cnt;
    if (c >= MAXW) c = MAXW - 1;
    // new column, oldest row first; line stores shift down one row
    fresh[0] = line_mem[2][c];
    fresh[1] = line_mem[1][c];
    fresh[2] = line_mem[0][c];
    fresh[3] = px;
    line_mem[2][c] = fresh[1];
    line_mem[1][c] = fresh[2];
    line_mem[0][c] = px;
    for (int i = 0; i < c2d4_pkg::KSIZE; i++) begin
      for (int j = 0; j < c2d4_pkg::KSIZE - 1; j++) win[i][j] = win[i][j+1];
      win[i][c2d4_pkg::KSIZE-1] = fresh[i];
    end
    row_end   = (c + 1 >= w);
    frame_end = (row_cnt + 1 >= h);
    if (row_cnt >= 3 && c >= 3) begin
      acc = 0;
      for (int i = 0; i < c2d4_pkg::KSIZE; i++)
        for (int j = 0; j < c2d4_pkg::KSIZE; j++)
          acc += kernel_tap(i * c2d4_pkg::KSIZE + j) * win[i][j];
      word.sum  = acc[c2d4_pkg::SUM_W-1:0];
      word.last = row_end && frame_end;
      expected_sums.push_back(word);
    end
    if (row_end) begin
      col_cnt = 0;
      row_cnt = frame_end ? 0 : ((row_cnt + 1) & 32'hFFFF);
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitors: every accepted pixel feeds the shadow model, every accepted
  // result word is matched against the oldest queued sum.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) convolve_pixel(pixel);
  end

  always @(posedge clk) begin : result_check
    sum_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $error("unexpected word: window_sum %0d frame_last %0b", window_sum, frame_last);
        errors++;
      end else begin
        want = expected_sums.pop_front();
        if (window_sum !== want.sum) begin
          $error("window_sum: expected %0d, got %0d", want.sum, window_sum);
          errors++;
        end
        if (frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, frame_last);
          errors++;
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Idle pattern: mostly back-to-back, some short gaps, a few long ones.
  // ---------------------------------------------------------------------------
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Sink side back-pressure.
  always @(posedge clk) begin : ready_gen
    int unsigned g;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!out_ready) begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 12);
    end else begin
      g = idle_len();
      if (g != 0) begin
        out_ready  <= 1'b0;
        ready_hold <= g - 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. All tasks are entered and left right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_pixel(input logic [c2d4_pkg::PIX_W-1:0] px);
    int unsigned gap;
    in_valid <= 1'b1;
    pixel    <= px;
    do @(posedge clk); while (!in_ready);
    gap = idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait until every queued sum has come back and the pipeline is empty.
  // The first edge lets the monitor queue the last accepted pixel's sum.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_reg(input c2d4_pkg::reg_idx_t idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_view(idx)) begin
      $error("prdata[%s]: expected %0h, got %0h", idx.name(), reg_view(idx), prdata);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Write a register, then read it straight back (back-to-back transfer).
  task automatic set_reg(input c2d4_pkg::reg_idx_t idx,
                         input logic [c2d4_pkg::CFG_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      c2d4_pkg::REG_COEF01: coef01 = val;
      c2d4_pkg::REG_COEF23: coef23 = val;
      c2d4_pkg::REG_IMG_W:  img_w  = val[c2d4_pkg::IMG_W_W-1:0];
      c2d4_pkg::REG_IMG_H:  img_h  = val[c2d4_pkg::IMG_H_W-1:0];
      default: ;
    endcase
    check_reg(idx);
  endtask

  function automatic logic [c2d4_pkg::PIX_W-1:0] pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 20) return '1;
    return c2d4_pkg::PIX_W'($urandom_range(0, 255));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values read back, then five rows at the reset kernel and 48-wide
  // frame; height is then cut to 4 mid-frame so the next row closes it.
  task automatic test_reset_defaults();
    check_reg(c2d4_pkg::REG_COEF01);
    check_reg(c2d4_pkg::REG_COEF23);
    check_reg(c2d4_pkg::REG_IMG_W);
    check_reg(c2d4_pkg::REG_IMG_H);
    repeat (5 * c2d4_pkg::RST_IMG_W) send_pixel(pick_pixel());
    drain();
    set_reg(c2d4_pkg::REG_IMG_H, 64'(c2d4_pkg::MIN_IMG_H));
    repeat (c2d4_pkg::RST_IMG_W) send_pixel(pick_pixel());
    drain();
  endtask

  // 5x4 frame, all taps 255: first window has a zero column, second is
  // all 255 and hits the maximum sum on the frame's last pixel.
  task automatic test_extreme_window();
    set_reg(c2d4_pkg::REG_COEF01, '1);
    set_reg(c2d4_pkg::REG_COEF23, '1);
    set_reg(c2d4_pkg::REG_IMG_W, 64'd5);
    set_reg(c2d4_pkg::REG_IMG_H, 64'(c2d4_pkg::MIN_IMG_H));
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 5; c++)
        send_pixel((c == 0) ? 8'd0 : 8'd255);
    drain();
  endtask

  // Phases of random settings: mostly whole rows, some cut short so the
  // next setting lands mid-row. Sizes include out-of-range values.
  task automatic test_random_frames();
    int unsigned sent, r, w, h, rows, n, pick;
    logic [c2d4_pkg::CFG_DATA_W-1:0] val;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        val = (r < 10) ? '0 : (r < 20) ? '1 : {$urandom(), $urandom()};
        set_reg(c2d4_pkg::REG_COEF01, val);
      end
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        val = (r < 10) ? '0 : (r < 20) ? '1 : {$urandom(), $urandom()};
        set_reg(c2d4_pkg::REG_COEF23, val);
      end
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        val = {$urandom(), $urandom()};
        pick = (r < 8)  ? $urandom_range(0, 3) :
               (r < 16) ? 4 :
               (r < 24) ? 64 :
               (r < 30) ? $urandom_range(65, 127) : $urandom_range(5, 12);
        val[c2d4_pkg::IMG_W_W-1:0] = c2d4_pkg::IMG_W_W'(pick);
        set_reg(c2d4_pkg::REG_IMG_W, val);
      end
      if ($urandom_range(0, 1)) begin
        r = $urandom_range(0, 99);
        val = {$urandom(), $urandom()};
        pick = (r < 8)  ? $urandom_range(0, 3) :
               (r < 14) ? 65535 :
               (r < 20) ? $urandom_range(9, 65534) : $urandom_range(4, 6);
        val[c2d4_pkg::IMG_H_W-1:0] = c2d4_pkg::IMG_H_W'(pick);
        set_reg(c2d4_pkg::REG_IMG_H, val);
      end
      w = width_used();
      h = height_used();
      if ($urandom_range(0, 3) != 0) begin
        rows = (h <= 6) ? h : $urandom_range(4, 6);
        if (w > 16) rows = 4;
        n = w * rows;
      end else begin
        n = $urandom_range(1, 3 * w);
      end
      repeat (n) send_pixel(pick_pixel());
      sent += n;
      drain();
    end
    steady = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_extreme_window();
    test_random_frames();
    drain();
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
